// File: rtl/upm_pkg.sv
`default_nettype none

package upm_pkg;

    localparam int CHAN_W    = 8;
    localparam int DIV_STEPS = CHAN_W;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_MIN = 8'h00;

    // source_format codes
    localparam logic FMT_BGRA = 1'b0;
    localparam logic FMT_GRAY = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] alpha_in;
        logic [CHAN_W-1:0] gray_in;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
    } pix_out_t;

    // per-word side information that travels beside the lanes
    typedef struct packed {
        logic              valid;
        logic              gray_mode;
        logic              bypass;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] gray;
    } meta_t;

endpackage

`default_nettype wire

// File: rtl/upm_lane.sv
`default_nettype none

// One color channel: floor(c*255/a) saturated at 255, by a restoring
// divider with one quotient bit per pipeline stage.
module upm_lane
    import upm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid_in,
    input  wire logic              bypass_in,
    input  wire logic [CHAN_W-1:0] chan_in,
    input  wire logic [CHAN_W-1:0] alpha_in,
    output logic      [CHAN_W-1:0] chan_out
);

    localparam int LAST = DIV_STEPS - 1;

    logic              vld_reg  [DIV_STEPS];
    logic              sat_reg  [DIV_STEPS];
    logic              byp_reg  [DIV_STEPS];
    logic [CHAN_W-1:0] rem_reg  [DIV_STEPS];
    logic [CHAN_W-1:0] low_reg  [DIV_STEPS];
    logic [CHAN_W-1:0] quo_reg  [DIV_STEPS];
    logic [CHAN_W-1:0] div_reg  [DIV_STEPS];
    logic [CHAN_W-1:0] chan_reg [DIV_STEPS];

    logic              vld_src  [DIV_STEPS];
    logic              sat_src  [DIV_STEPS];
    logic              byp_src  [DIV_STEPS];
    logic [CHAN_W-1:0] rem_src  [DIV_STEPS];
    logic [CHAN_W-1:0] low_src  [DIV_STEPS];
    logic [CHAN_W-1:0] quo_src  [DIV_STEPS];
    logic [CHAN_W-1:0] div_src  [DIV_STEPS];
    logic [CHAN_W-1:0] chan_src [DIV_STEPS];

    logic [CHAN_W-1:0] rem_next [DIV_STEPS];
    logic [CHAN_W-1:0] low_next [DIV_STEPS];
    logic [CHAN_W-1:0] quo_next [DIV_STEPS];

    logic [2*CHAN_W-1:0] prod;

    // c*255 = (c << 8) - c; the top byte starts the remainder, which is
    // below a whenever c < a
    assign prod = {chan_in, CHAN_MIN} - {CHAN_MIN, chan_in};

    always_comb
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            if (s == 0)
            begin
                vld_src[s]  = valid_in;
                sat_src[s]  = (chan_in >= alpha_in);
                byp_src[s]  = bypass_in;
                rem_src[s]  = prod[2*CHAN_W-1:CHAN_W];
                low_src[s]  = prod[CHAN_W-1:0];
                quo_src[s]  = CHAN_MIN;
                div_src[s]  = alpha_in;
                chan_src[s] = chan_in;
            end
            else
            begin
                vld_src[s]  = vld_reg[s-1];
                sat_src[s]  = sat_reg[s-1];
                byp_src[s]  = byp_reg[s-1];
                rem_src[s]  = rem_reg[s-1];
                low_src[s]  = low_reg[s-1];
                quo_src[s]  = quo_reg[s-1];
                div_src[s]  = div_reg[s-1];
                chan_src[s] = chan_reg[s-1];
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            logic [CHAN_W:0] trial;
            logic            fits;
            trial = {rem_src[s], low_src[s][CHAN_W-1]};
            fits  = (trial >= {1'b0, div_src[s]});
            if (fits)
                trial = trial - {1'b0, div_src[s]};
            rem_next[s] = trial[CHAN_W-1:0];
            low_next[s] = {low_src[s][CHAN_W-2:0], 1'b0};
            quo_next[s] = {quo_src[s][CHAN_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
                vld_reg[s] <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < DIV_STEPS; s++)
                vld_reg[s] <= vld_src[s];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            sat_reg[s]  <= sat_src[s];
            byp_reg[s]  <= byp_src[s];
            rem_reg[s]  <= rem_next[s];
            low_reg[s]  <= low_next[s];
            quo_reg[s]  <= quo_next[s];
            div_reg[s]  <= div_src[s];
            chan_reg[s] <= chan_src[s];
        end
    end

    always_comb
    begin
        if (byp_reg[LAST])
            chan_out = chan_reg[LAST];
        else if (sat_reg[LAST])
            chan_out = CHAN_MAX;
        else
            chan_out = quo_reg[LAST];
    end

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAST] && !sat_reg[LAST] |-> rem_reg[LAST] < div_reg[LAST])
        else $error("lane remainder not below divisor");

    a_quo_unsat: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAST] && !sat_reg[LAST] |-> quo_reg[LAST] != CHAN_MAX)
        else $error("lane quotient reached max without saturation");

endmodule

`default_nettype wire

// File: rtl/upm_merge.sv
`default_nettype none

// Reorders lane results to RGBA, applies gray mode, registers the word.
module upm_merge
    import upm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire meta_t             meta,
    input  wire logic [CHAN_W-1:0] red_lane,
    input  wire logic [CHAN_W-1:0] green_lane,
    input  wire logic [CHAN_W-1:0] blue_lane,
    output logic                   done,
    output pix_out_t               result
);

    logic     done_reg;
    pix_out_t result_reg;
    pix_out_t result_next;

    always_comb
    begin
        if (meta.gray_mode == FMT_GRAY)
        begin
            result_next.red_out   = CHAN_MAX;
            result_next.green_out = CHAN_MAX;
            result_next.blue_out  = CHAN_MAX;
            result_next.alpha_out = meta.gray;
        end
        else
        begin
            result_next.red_out   = red_lane;
            result_next.green_out = green_lane;
            result_next.blue_out  = blue_lane;
            result_next.alpha_out = meta.alpha;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= meta.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_gray_white: assert property (@(posedge clk) disable iff (!rst_n)
        meta.valid && meta.gray_mode == FMT_GRAY |=>
            done && result.red_out == CHAN_MAX && result.green_out == CHAN_MAX
            && result.blue_out == CHAN_MAX)
        else $error("gray word not white");

endmodule

`default_nettype wire

// File: rtl/unpremultiply_bgra_to_rgba.sv
`default_nettype none

// Alpha unpremultiply, BGRA or gray coverage in, straight RGBA out.
//
// Input: a word on pixel is taken at a rising edge with start high and
// busy low. busy stays low, so a word can be taken every clock.
// Output: each result sits on result for one cycle with done high; the
// receiver cannot stall, and nothing is held back.
// Path: a word passes the input register, 8 divider stages and the
// output register before its result is shown on result.
// Throughput: one word per clock; the three color lanes each run a
// restoring divider pipelined at one quotient bit per stage.
// Configuration: cfg_data (source_format) is written when cfg_valid is
// high; cfg_ready is always high. Write it only with no words in flight.
// Reset: clears the pipeline valids and sets source_format to BGRA.
module unpremultiply_bgra_to_rgba
    import upm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire pix_in_t  pixel,
    output logic          done,
    output pix_out_t      result,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic     cfg_data
);

    logic    format_reg;
    pix_in_t pix_reg;
    meta_t   meta_reg [DIV_STEPS+1];
    meta_t   meta_next;
    logic    accept;

    logic [CHAN_W-1:0] red_lane;
    logic [CHAN_W-1:0] green_lane;
    logic [CHAN_W-1:0] blue_lane;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            format_reg <= FMT_BGRA;
        else if (cfg_valid && cfg_ready)
            format_reg <= cfg_data;
    end

    always_comb
    begin
        meta_next.valid     = accept;
        meta_next.gray_mode = format_reg;
        meta_next.bypass    = (pixel.alpha_in == CHAN_MIN) || (pixel.alpha_in == CHAN_MAX);
        meta_next.alpha     = pixel.alpha_in;
        meta_next.gray      = pixel.gray_in;
    end

    // side line aligned with the lane pipelines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STEPS; s++)
                meta_reg[s] <= '0;
        end
        else
        begin
            meta_reg[0] <= meta_next;
            for (int s = 1; s <= DIV_STEPS; s++)
                meta_reg[s] <= meta_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pixel;
    end

    upm_lane u_lane_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (meta_reg[0].valid),
        .bypass_in (meta_reg[0].bypass),
        .chan_in   (pix_reg.red_in),
        .alpha_in  (pix_reg.alpha_in),
        .chan_out  (red_lane)
    );

    upm_lane u_lane_green (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (meta_reg[0].valid),
        .bypass_in (meta_reg[0].bypass),
        .chan_in   (pix_reg.green_in),
        .alpha_in  (pix_reg.alpha_in),
        .chan_out  (green_lane)
    );

    upm_lane u_lane_blue (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (meta_reg[0].valid),
        .bypass_in (meta_reg[0].bypass),
        .chan_in   (pix_reg.blue_in),
        .alpha_in  (pix_reg.alpha_in),
        .chan_out  (blue_lane)
    );

    upm_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .meta       (meta_reg[DIV_STEPS]),
        .red_lane   (red_lane),
        .green_lane (green_lane),
        .blue_lane  (blue_lane),
        .done       (done),
        .result     (result)
    );

    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, DIV_STEPS + 2))
        else $error("result word without matching accepted word");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`default_nettype none

module testbench;
    import upm_pkg::*;

    // Keeps the format register's copy and the straight-alpha pixels still owed by the dut.
    class pixel_checker;
        pix_out_t pending_pixels[$];
        logic     format;
        int       mismatches;

        function new();
            format     = FMT_BGRA;
            mismatches = 0;
        endfunction

        function logic [CHAN_W-1:0] unpremul(logic [CHAN_W-1:0] c, logic [CHAN_W-1:0] a);
            int q;
            q = (int'(c) * int'(CHAN_MAX)) / int'(a);
            return (q > int'(CHAN_MAX)) ? CHAN_MAX : CHAN_W'(q);
        endfunction

        function pix_out_t straight_pixel(pix_in_t p);
            pix_out_t o;
            if (format == FMT_GRAY)
            begin
                o.red_out   = CHAN_MAX;
                o.green_out = CHAN_MAX;
                o.blue_out  = CHAN_MAX;
                o.alpha_out = p.gray_in;
            end
            else if (p.alpha_in != CHAN_MIN && p.alpha_in != CHAN_MAX)
            begin
                o.red_out   = unpremul(p.red_in, p.alpha_in);
                o.green_out = unpremul(p.green_in, p.alpha_in);
                o.blue_out  = unpremul(p.blue_in, p.alpha_in);
                o.alpha_out = p.alpha_in;
            end
            else
            begin
                // zero or full alpha: colors go through as they are
                o.red_out   = p.red_in;
                o.green_out = p.green_in;
                o.blue_out  = p.blue_in;
                o.alpha_out = p.alpha_in;
            end
            return o;
        endfunction

        function void note_pixel(pix_in_t p);
            pending_pixels.insert(pending_pixels.size(), straight_pixel(p));
        endfunction

        function void compare_field(string name, logic [CHAN_W-1:0] want,
                                    logic [CHAN_W-1:0] got);
            if (got !== want)
            begin
                $error("%s expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(pix_out_t got);
            pix_out_t want;
            if (pending_pixels.size() == 0)
            begin
                $error("result word %h with no pixel pending", got);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("red_out", want.red_out, got.red_out);
            compare_field("green_out", want.green_out, got.green_out);
            compare_field("blue_out", want.blue_out, got.blue_out);
            compare_field("alpha_out", want.alpha_out, got.alpha_out);
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     start     = 1'b0;
    logic     busy;
    pix_in_t  pixel     = '0;
    logic     done;
    pix_out_t result;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_data  = 1'b0;

    pixel_checker sb;

    unpremultiply_bgra_to_rgba dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(result);
    end

    function automatic pix_in_t px(int b, int g, int r, int a, int v);
        pix_in_t p;
        p.blue_in  = CHAN_W'(b);
        p.green_in = CHAN_W'(g);
        p.red_in   = CHAN_W'(r);
        p.alpha_in = CHAN_W'(a);
        p.gray_in  = CHAN_W'(v);
        return p;
    endfunction

    // mostly well-formed premultiplied words (color <= alpha), alpha often at the edges
    function automatic pix_in_t random_pixel();
        pix_in_t p;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       p.alpha_in = CHAN_MIN;
            1:       p.alpha_in = CHAN_MAX;
            2:       p.alpha_in = 8'd1;
            3:       p.alpha_in = 8'd254;
            default: p.alpha_in = CHAN_W'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 4) == 0)
        begin
            p.blue_in  = CHAN_W'($urandom_range(0, 255));
            p.green_in = CHAN_W'($urandom_range(0, 255));
            p.red_in   = CHAN_W'($urandom_range(0, 255));
        end
        else
        begin
            p.blue_in  = CHAN_W'($urandom_range(0, p.alpha_in));
            p.green_in = CHAN_W'($urandom_range(0, p.alpha_in));
            p.red_in   = CHAN_W'($urandom_range(0, p.alpha_in));
        end
        p.gray_in = CHAN_W'($urandom_range(0, 255));
        return p;
    endfunction

    task automatic send_pixel(input pix_in_t p);
        start <= 1'b1;
        pixel <= p;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_pixel(p);
    endtask

    task automatic maybe_idle(input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_format(input logic fmt);
        cfg_valid <= 1'b1;
        cfg_data  <= fmt;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.format = fmt;
    endtask

    initial
    begin
        int idle_pct;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_format(FMT_BGRA);
        send_pixel(px(0, 0, 0, 0, 0));
        send_pixel(px(255, 128, 1, 0, 255));     // zero alpha
        send_pixel(px(255, 200, 7, 255, 0));     // full alpha
        send_pixel(px(0, 0, 1, 1, 0));
        send_pixel(px(1, 0, 255, 1, 0));         // red far above alpha
        send_pixel(px(127, 128, 129, 128, 0));
        send_pixel(px(254, 253, 255, 254, 0));
        send_pixel(px(100, 50, 200, 200, 0));
        send_pixel(px(8'h55, 8'hAA, 8'h0F, 8'h80, 8'hFF));
        send_pixel(px(8'hAA, 8'h55, 8'hF0, 8'h7F, 8'h00));
        send_pixel(px(3, 2, 1, 2, 8'h5A));
        send_pixel(px(255, 255, 255, 255, 8'hA5));
        drain();

        write_format(FMT_GRAY);
        send_pixel(px(0, 0, 0, 0, 0));
        send_pixel(px(255, 255, 255, 255, 255));
        send_pixel(px(1, 2, 3, 128, 8'h5A));     // bgra fields ignored here
        send_pixel(px(8'hAA, 8'h55, 8'hF0, 0, 8'hA5));
        send_pixel(px(0, 0, 0, 255, 1));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_format(ph[0] ? FMT_GRAY : FMT_BGRA);
            // receiver can't stall, so the phases vary only the sender's idle share
            case (ph % 4)
                1:       idle_pct = 54;
                3:       idle_pct = 29;
                default: idle_pct = 0;
            endcase
            repeat (225)
            begin
                send_pixel(random_pixel());
                maybe_idle(idle_pct);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.pending_pixels.size() != 0)
        begin
            $error("%0d result words never arrived", sb.pending_pixels.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
